### hdl/arpr_pkg.sv
// ----------------------------------------------------------------------------
// arpr_pkg
// shared types, codes and constants of the arp resolver with retry backoff
// ----------------------------------------------------------------------------
`default_nettype none

package arpr_pkg;

  // bytes in a hardware address, checked against the reply hw_len field
  localparam int unsigned MacBytes = 6;

  localparam int unsigned IpW    = 32;
  localparam int unsigned MacW   = MacBytes * 8;
  localparam int unsigned WaitW  = 10;
  localparam int unsigned RetryW = 4;

  // packed input fields behind req_type, lowest field first
  localparam int unsigned InFieldW = IpW + 1 + 16 + 16 + 8 + 8 + 16 + MacW + IpW + MacW + IpW;

  // stream and config port widths, stream data filled up to whole bytes
  localparam int unsigned InDataW   = (InFieldW + 7) / 8 * 8;
  localparam int unsigned OutDataW  = (IpW + MacW + 7) / 8 * 8;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = MacW;

  // arp header values of an acceptable reply
  localparam logic [15:0] ArpHwEthernet = 16'h0001;
  localparam logic [15:0] ArpProtoIpv4  = 16'h0800;
  localparam logic [15:0] ArpOpReply    = 16'h0002;
  localparam logic [7:0]  ArpHwLen      = 8'(MacBytes);
  localparam logic [7:0]  ArpProtoLen   = 8'd4;

  // register reset values
  localparam logic [RetryW-1:0] MaxRetriesRst  = 4'd15;
  localparam logic [WaitW-1:0]  InitTimeoutRst = 10'd25;
  localparam logic [WaitW-1:0]  TimeoutCapRst  = 10'd500;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ARP    = 2'd1,
    REQ_TICK   = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    RES_REQUEST  = 2'd0,
    RES_RESOLVED = 2'd1,
    RES_FAILED   = 2'd2
  } result_kind_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_OWN_IP       = 3'd0,
    CFG_OWN_MAC      = 3'd1,
    CFG_MAX_RETRIES  = 3'd2,
    CFG_INIT_TIMEOUT = 3'd3,
    CFG_TIMEOUT_CAP  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    req_type_e         req_type;
    logic [IpW-1:0]    lookup_ip;
    logic              frame_long_enough;
    logic [15:0]       hw_type;
    logic [15:0]       proto_type;
    logic [7:0]        hw_len;
    logic [7:0]        proto_len;
    logic [15:0]       opcode;
    logic [MacW-1:0]   sender_mac;
    logic [IpW-1:0]    sender_ip;
    logic [MacW-1:0]   target_mac;
    logic [IpW-1:0]    target_ip;
  } item_t;

  typedef struct packed {
    result_kind_e      kind;
    logic [IpW-1:0]    request_ip;
    logic [MacW-1:0]   resolved_mac;
  } result_t;

  // double the wait and clamp it to the cap
  function automatic logic [WaitW-1:0] doubled_capped(input logic [WaitW-1:0] w,
                                                      input logic [WaitW-1:0] cap);
    logic [WaitW:0] d;
    d = {w, 1'b0};
    if (d > {1'b0, cap}) begin
      return cap;
    end
    return d[WaitW-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/arpr_ingress.sv
// ----------------------------------------------------------------------------
// arpr_ingress
// input register: takes one stream transaction and unpacks its fields
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_ingress (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [arpr_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic [1:0]                    s_axis_tuser,
  input  wire logic                          advance_i,
  output logic                               item_valid_o,
  output arpr_pkg::item_t                    item_o
);

  logic            valid_q, valid_d;
  arpr_pkg::item_t item_q, item_d;
  logic            take;

  assign s_axis_tready = !valid_q || advance_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  // fields sit in tdata from lookup_ip at the bottom up to target_ip
  always_comb begin
    item_d.req_type = arpr_pkg::req_type_e'(s_axis_tuser);
    {item_d.target_ip, item_d.target_mac, item_d.sender_ip, item_d.sender_mac,
     item_d.opcode, item_d.proto_len, item_d.hw_len, item_d.proto_type,
     item_d.hw_type, item_d.frame_long_enough, item_d.lookup_ip}
      = s_axis_tdata[arpr_pkg::InFieldW-1:0];
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

### hdl/arpr_engine.sv
// ----------------------------------------------------------------------------
// arpr_engine
// config registers, cache entry, retry state and the per-item decision
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_engine (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [arpr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [arpr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                           fire_i,
  input  wire arpr_pkg::item_t                item_i,
  output logic                                res_valid_o,
  output arpr_pkg::result_t                   res_o
);

  // config registers
  logic [arpr_pkg::IpW-1:0]    own_ip_q;
  logic [arpr_pkg::MacW-1:0]   own_mac_q;
  logic [arpr_pkg::RetryW-1:0] max_retries_q;
  logic [arpr_pkg::WaitW-1:0]  init_timeout_q;
  logic [arpr_pkg::WaitW-1:0]  timeout_cap_q;

  // resolver state
  logic [arpr_pkg::IpW-1:0]    cached_ip_q, cached_ip_d;
  logic [arpr_pkg::MacW-1:0]   cached_mac_q, cached_mac_d;
  logic                        busy_q, busy_d;
  logic [arpr_pkg::IpW-1:0]    pending_ip_q, pending_ip_d;
  logic [arpr_pkg::RetryW-1:0] retries_left_q, retries_left_d;
  logic [arpr_pkg::WaitW-1:0]  next_wait_q, next_wait_d;
  logic [arpr_pkg::WaitW-1:0]  countdown_q, countdown_d;

  logic reply_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q       <= '0;
      own_mac_q      <= '0;
      max_retries_q  <= arpr_pkg::MaxRetriesRst;
      init_timeout_q <= arpr_pkg::InitTimeoutRst;
      timeout_cap_q  <= arpr_pkg::TimeoutCapRst;
    end else if (cfg_we_i) begin
      case (arpr_pkg::cfg_idx_e'(cfg_addr_i))
        arpr_pkg::CFG_OWN_IP:       own_ip_q       <= cfg_wdata_i[arpr_pkg::IpW-1:0];
        arpr_pkg::CFG_OWN_MAC:      own_mac_q      <= cfg_wdata_i[arpr_pkg::MacW-1:0];
        arpr_pkg::CFG_MAX_RETRIES:  max_retries_q  <= cfg_wdata_i[arpr_pkg::RetryW-1:0];
        arpr_pkg::CFG_INIT_TIMEOUT: init_timeout_q <= cfg_wdata_i[arpr_pkg::WaitW-1:0];
        arpr_pkg::CFG_TIMEOUT_CAP:  timeout_cap_q  <= cfg_wdata_i[arpr_pkg::WaitW-1:0];
        default: ;
      endcase
    end
  end

  assign reply_ok = item_i.frame_long_enough
                 && (item_i.hw_type    == arpr_pkg::ArpHwEthernet)
                 && (item_i.proto_type == arpr_pkg::ArpProtoIpv4)
                 && (item_i.hw_len     == arpr_pkg::ArpHwLen)
                 && (item_i.proto_len  == arpr_pkg::ArpProtoLen)
                 && (item_i.opcode     == arpr_pkg::ArpOpReply)
                 && (item_i.target_mac == own_mac_q)
                 && (item_i.target_ip  == own_ip_q)
                 && (item_i.sender_ip  == pending_ip_q);

  always_comb begin
    cached_ip_d        = cached_ip_q;
    cached_mac_d       = cached_mac_q;
    busy_d             = busy_q;
    pending_ip_d       = pending_ip_q;
    retries_left_d     = retries_left_q;
    next_wait_d        = next_wait_q;
    countdown_d        = countdown_q;
    res_valid_o        = 1'b0;
    res_o.kind         = arpr_pkg::RES_REQUEST;
    res_o.request_ip   = '0;
    res_o.resolved_mac = '0;
    if (fire_i) begin
      case (item_i.req_type)
        arpr_pkg::REQ_LOOKUP: begin
          if (!busy_q) begin
            res_valid_o      = 1'b1;
            res_o.request_ip = item_i.lookup_ip;
            if (item_i.lookup_ip == cached_ip_q) begin
              res_o.kind         = arpr_pkg::RES_RESOLVED;
              res_o.resolved_mac = cached_mac_q;
            end else if (max_retries_q == '0) begin
              res_o.kind = arpr_pkg::RES_FAILED;
            end else begin
              busy_d         = 1'b1;
              pending_ip_d   = item_i.lookup_ip;
              retries_left_d = max_retries_q - 1'b1;
              countdown_d    = init_timeout_q;
              next_wait_d    = arpr_pkg::doubled_capped(init_timeout_q, timeout_cap_q);
            end
          end
        end
        arpr_pkg::REQ_ARP: begin
          if (busy_q && reply_ok) begin
            cached_ip_d        = pending_ip_q;
            cached_mac_d       = item_i.sender_mac;
            busy_d             = 1'b0;
            res_valid_o        = 1'b1;
            res_o.kind         = arpr_pkg::RES_RESOLVED;
            res_o.request_ip   = pending_ip_q;
            res_o.resolved_mac = item_i.sender_mac;
          end
        end
        arpr_pkg::REQ_TICK: begin
          if (busy_q) begin
            if (countdown_q > arpr_pkg::WaitW'(1)) begin
              countdown_d = countdown_q - 1'b1;
            end else begin
              res_valid_o      = 1'b1;
              res_o.request_ip = pending_ip_q;
              if (retries_left_q == '0) begin
                busy_d      = 1'b0;
                countdown_d = '0;
                res_o.kind  = arpr_pkg::RES_FAILED;
              end else begin
                retries_left_d = retries_left_q - 1'b1;
                countdown_d    = next_wait_q;
                next_wait_d    = arpr_pkg::doubled_capped(next_wait_q, timeout_cap_q);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cached_ip_q    <= '0;
      cached_mac_q   <= '0;
      busy_q         <= 1'b0;
      pending_ip_q   <= '0;
      retries_left_q <= '0;
      next_wait_q    <= '0;
      countdown_q    <= '0;
    end else begin
      cached_ip_q    <= cached_ip_d;
      cached_mac_q   <= cached_mac_d;
      busy_q         <= busy_d;
      pending_ip_q   <= pending_ip_d;
      retries_left_q <= retries_left_d;
      next_wait_q    <= next_wait_d;
      countdown_q    <= countdown_d;
    end
  end

`ifndef SYNTHESIS
  // a request always leaves the resolver waiting
  a_request_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == arpr_pkg::RES_REQUEST) |=> busy_q)
    else $error("request issued but resolver not busy");

  // resolved or failed always leaves the resolver idle
  a_final_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind != arpr_pkg::RES_REQUEST) |=> !busy_q)
    else $error("final result but resolver still busy");

  // busy only starts together with a request
  a_busy_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(res_valid_o && res_o.kind == arpr_pkg::RES_REQUEST))
    else $error("resolver went busy without a request");

  // the cache only changes on a resolved reply
  a_cache_on_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cached_mac_q) |-> $past(res_valid_o && res_o.kind == arpr_pkg::RES_RESOLVED))
    else $error("cache written without a resolved reply");
`endif

endmodule

`default_nettype wire

### hdl/arpr_egress.sv
// ----------------------------------------------------------------------------
// arpr_egress
// result register driving the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module arpr_egress (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           load_i,
  input  wire logic                           res_valid_i,
  input  wire arpr_pkg::result_t              res_i,
  output logic                                ready_o,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [arpr_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic [1:0]                          m_axis_tuser
);

  logic              valid_q, valid_d;
  arpr_pkg::result_t res_q;

  assign ready_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = arpr_pkg::OutDataW'({res_q.resolved_mac, res_q.request_ip});
  assign m_axis_tuser  = res_q.kind;

endmodule

`default_nettype wire

### hdl/arp_resolver_with_backoff_core.sv
// a result passes through the input register and then the result register before it shows on m_axis
// throughput: one input transaction per cycle while m_axis_tready does not stall the output, set by
//   the combinational decision logic between the input register and the result register
// items that cause no result still pass through the result register and leave a gap in the output stream
// reset (rst_ni low, asynchronous): cache cleared to ip 0 / mac 0, resolver idle,
//   registers back to their defaults (max retries 15, timeout 25, cap 500)
// ----------------------------------------------------------------------------
// arp_resolver_with_backoff_core
// single-entry arp resolver with doubling retry timeout
// ----------------------------------------------------------------------------
`default_nettype none

module arp_resolver_with_backoff_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  // configuration writes, index = register number
  input  wire logic                           cfg_we_i,
  input  wire logic [arpr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [arpr_pkg::CfgDataW-1:0]  cfg_wdata_i,

  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // lookup_ip, frame_long_enough, hw_type, proto_type, hw_len, proto_len,
  // opcode, sender_mac, sender_ip, target_mac, target_ip, zero pad
  input  wire logic [arpr_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type
  input  wire logic [1:0]                     s_axis_tuser,

  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // request_ip, resolved_mac
  output logic [arpr_pkg::OutDataW-1:0]       m_axis_tdata,
  // result_kind
  output logic [1:0]                          m_axis_tuser
);

  logic              advance;     // result register can take the next decision
  logic              item_valid;
  logic              fire;        // item in the input register is processed now
  arpr_pkg::item_t   item;
  logic              res_valid;
  arpr_pkg::result_t res;

  // input register, refills in the same cycle it drains
  arpr_ingress u_ingress (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance_i     (advance),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  assign fire = item_valid && advance;

  // state updates happen exactly once per item, when it moves into the result stage
  arpr_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register, holds a result until the sink takes it
  arpr_egress u_egress (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .ready_o       (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
